// File: src/greedy_word_wrap_line_breaker_defines.svh
// assertion macros of the word wrap line breaker rtl
// no dependencies; files that assert include this header
`ifndef GREEDY_WORD_WRAP_LINE_BREAKER_DEFINES_SVH
`define GREEDY_WORD_WRAP_LINE_BREAKER_DEFINES_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define GWWLB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gwwlb assertion failed");

// expression must never be true outside reset
`define GWWLB_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("gwwlb forbidden condition seen");

`else

`define GWWLB_ASSERT(label, clk, rst_n, prop)
`define GWWLB_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: src/gwwlb_pkg.sv
// shared types, constants and the character classifier of the line breaker
// no dependencies
package gwwlb_pkg;

  localparam int CHAR_W            = 8;
  localparam int WRAP_W            = 6;
  localparam int LINE_CAPACITY_DEF = 64;
  localparam int CMD_DEPTH         = 2;
  localparam int OUT_DEPTH         = 2;
  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;

  localparam logic [WRAP_W-1:0] WRAP_WIDTH_RST = 6'd63;

  // register word index, taken from paddr[APB_ADDR_W-1:2]
  localparam logic [APB_ADDR_W-3:0] REG_WRAP_WIDTH = 1'b0;

  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_VTAB    = 8'd11;
  localparam logic [CHAR_W-1:0] CHAR_FF      = 8'd12;
  localparam logic [CHAR_W-1:0] CHAR_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

  typedef enum logic [1:0] {
    CLS_WORD,
    CLS_BLANK,
    CLS_NEWLINE
  } cls_e;

  typedef struct packed {
    cls_e              cls;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  function automatic cls_e classify(input logic [CHAR_W-1:0] c);
    cls_e k;
    if (c == CHAR_NEWLINE) begin
      k = CLS_NEWLINE;
    end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VTAB ||
                 c == CHAR_FF || c == CHAR_CR) begin
      k = CLS_BLANK;
    end else begin
      k = CLS_WORD;
    end
    return k;
  endfunction

endpackage

// File: src/gwwlb_front.sv
// input side: takes characters, classifies them and queues commands
// depends on gwwlb_pkg
module gwwlb_front import gwwlb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] ch
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          queue_q [CMD_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign s_axis_tready = (cnt_q != CW'(CMD_DEPTH));
  assign cmd_valid_o   = (cnt_q != '0);
  assign cmd_o         = queue_q[rd_ptr_q];

  assign push = s_axis_tvalid && s_axis_tready;
  assign pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // classification happens on the way in
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= '{cls: classify(s_axis_tdata), ch: s_axis_tdata};
    end
  end

endmodule

// File: src/gwwlb_back.sv
// execution side: line store ring, word tracking, line emission, result buffer
// depends on gwwlb_pkg and greedy_word_wrap_line_breaker_defines.svh
`include "greedy_word_wrap_line_breaker_defines.svh"

module gwwlb_back import gwwlb_pkg::*; #(
  parameter int LineCapacity = LINE_CAPACITY_DEF,
  localparam int AW = $clog2(LineCapacity),
  localparam int LW = $clog2(LineCapacity + 2)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  input  logic [LW-1:0]     eff_width_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [CHAR_W-1:0] m_axis_tdata,   // [7:0] out_char
  output logic              m_axis_tuser,   // [0] empty_line
  output logic              m_axis_tlast
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  localparam int OPW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic              empty;
    logic              last;
    logic [CHAR_W-1:0] ch;
  } res_t;

  // line store as a ring: carrying a word over only moves the base
  logic [CHAR_W-1:0] line_mem_q [LineCapacity];
  logic [CHAR_W-1:0] rd_data_q;

  logic          state_q, state_d;
  logic [AW-1:0] base_q, base_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] lwe_q, lwe_d;
  logic [LW-1:0] ws_q, ws_d;
  logic          in_word_q, in_word_d;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] k_q, k_d;
  logic [LW-1:0] emit_n_q, emit_n_d;
  logic          emit_empty_q, emit_empty_d;

  logic rd_valid_q, rd_valid_d;
  logic rd_last_q, rd_last_d;
  logic rd_empty_q, rd_empty_d;

  res_t           out_q [OUT_DEPTH];
  logic [OPW-1:0] out_wr_q, out_rd_q;
  logic [OCW-1:0] out_cnt_q;
  logic           out_push, out_pop, space_ok;

  logic          mem_we, rd_en;
  logic [AW-1:0] wr_addr;

  logic [LW-1:0] len_s, lwe_s, ws_s, n_s, from_s;
  logic          in_word_s, emit_s, carry_s, clear_s, last_s;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [LW-1:0] b);
    logic [LW:0] s;
    s = (LW+1)'(a) + (LW+1)'(b);
    if (s >= (LW+1)'(LineCapacity)) begin
      s = s - (LW+1)'(LineCapacity);
    end
    return AW'(s);
  endfunction

  assign wr_addr  = ring_add(base_q, len_q);
  assign out_push = rd_valid_q;
  assign out_pop  = m_axis_tvalid && m_axis_tready;
  // a read issued now passes through rd_data_q and rd_valid_q before it enters the result buffer; keep room for it
  assign space_ok = ((OCW+1)'(out_cnt_q) + (OCW+1)'(rd_valid_q)) <
                    ((OCW+1)'(OUT_DEPTH) + (OCW+1)'(out_pop));
  assign last_s   = emit_empty_q || ((LW'(k_q) + LW'(1)) == emit_n_q);

  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    len_d        = len_q;
    lwe_d        = lwe_q;
    ws_d         = ws_q;
    in_word_d    = in_word_q;
    ptr_d        = ptr_q;
    k_d          = k_q;
    emit_n_d     = emit_n_q;
    emit_empty_d = emit_empty_q;
    rd_valid_d   = 1'b0;
    rd_last_d    = rd_last_q;
    rd_empty_d   = rd_empty_q;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    cmd_pop_o    = 1'b0;
    len_s        = len_q;
    lwe_s        = lwe_q;
    ws_s         = ws_q;
    in_word_s    = in_word_q;
    n_s          = '0;
    from_s       = '0;
    emit_s       = 1'b0;
    carry_s      = 1'b0;
    clear_s      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.cls == CLS_NEWLINE) begin
            emit_s  = 1'b1;
            n_s     = len_q;
            clear_s = 1'b1;
          end else begin
            if (cmd_i.cls == CLS_BLANK) begin
              if (in_word_q) begin
                lwe_s     = len_q;
                in_word_s = 1'b0;
              end
              ws_s = len_q + 1'b1;
            end else begin
              in_word_s = 1'b1;
            end
            if (len_q < LW'(LineCapacity)) begin
              mem_we = 1'b1;
              len_s  = len_q + 1'b1;
            end
            if (len_s > eff_width_i) begin
              emit_s = 1'b1;
              if (!in_word_s) begin
                // wrapped between words
                n_s     = lwe_s;
                clear_s = 1'b1;
              end else if (ws_s == '0) begin
                // word fills the whole line: hard break at the width
                n_s     = eff_width_i;
                from_s  = eff_width_i;
                carry_s = 1'b1;
              end else begin
                n_s     = lwe_s;
                from_s  = ws_s;
                carry_s = 1'b1;
              end
            end
          end

          if (clear_s) begin
            len_d     = '0;
            lwe_d     = '0;
            ws_d      = '0;
            in_word_d = 1'b0;
          end else if (carry_s) begin
            base_d    = ring_add(base_q, from_s);
            len_d     = (from_s < len_s) ? len_s - from_s : '0;
            lwe_d     = '0;
            ws_d      = '0;
            in_word_d = (from_s < len_s);
          end else begin
            len_d     = len_s;
            lwe_d     = lwe_s;
            ws_d      = ws_s;
            in_word_d = in_word_s;
          end

          if (emit_s) begin
            state_d      = ST_EMIT;
            ptr_d        = base_q;
            k_d          = '0;
            emit_n_d     = n_s;
            emit_empty_d = (n_s == '0);
          end
        end
      end
      ST_EMIT: begin
        if (space_ok) begin
          rd_en      = !emit_empty_q;
          rd_valid_d = 1'b1;
          rd_last_d  = last_s;
          rd_empty_d = emit_empty_q;
          ptr_d      = (ptr_q == AW'(LineCapacity - 1)) ? '0 : ptr_q + 1'b1;
          k_d        = k_q + 1'b1;
          if (last_s) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      base_q       <= '0;
      len_q        <= '0;
      lwe_q        <= '0;
      ws_q         <= '0;
      in_word_q    <= 1'b0;
      ptr_q        <= '0;
      k_q          <= '0;
      emit_n_q     <= '0;
      emit_empty_q <= 1'b0;
      rd_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      base_q       <= base_d;
      len_q        <= len_d;
      lwe_q        <= lwe_d;
      ws_q         <= ws_d;
      in_word_q    <= in_word_d;
      ptr_q        <= ptr_d;
      k_q          <= k_d;
      emit_n_q     <= emit_n_d;
      emit_empty_q <= emit_empty_d;
      rd_valid_q   <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_last_q  <= rd_last_d;
    rd_empty_q <= rd_empty_d;
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem_q[wr_addr] <= cmd_i.ch;
    end
    if (rd_en) begin
      rd_data_q <= line_mem_q[ptr_q];
    end
  end

  // result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (out_push) begin
        out_wr_q <= (out_wr_q == OPW'(OUT_DEPTH - 1)) ? '0 : out_wr_q + 1'b1;
      end
      if (out_pop) begin
        out_rd_q <= (out_rd_q == OPW'(OUT_DEPTH - 1)) ? '0 : out_rd_q + 1'b1;
      end
      case ({out_push, out_pop})
        2'b10:   out_cnt_q <= out_cnt_q + 1'b1;
        2'b01:   out_cnt_q <= out_cnt_q - 1'b1;
        default: out_cnt_q <= out_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_q[out_wr_q] <= '{empty: rd_empty_q, last: rd_last_q,
                           ch: rd_empty_q ? '0 : rd_data_q};
    end
  end

  assign m_axis_tvalid = (out_cnt_q != '0);
  assign m_axis_tdata  = out_q[out_rd_q].ch;
  assign m_axis_tuser  = out_q[out_rd_q].empty;
  assign m_axis_tlast  = out_q[out_rd_q].last;

  `GWWLB_ASSERT(a_len_in_range, clk_i, rst_ni, len_q <= LW'(LineCapacity))
  `GWWLB_ASSERT(a_word_end_in_line, clk_i, rst_ni, lwe_q <= len_q)
  `GWWLB_ASSERT(a_newline_clears, clk_i, rst_ni, (cmd_pop_o && cmd_i.cls == CLS_NEWLINE) |=> (len_q == '0 && !in_word_q))
  `GWWLB_ASSERT(a_read_only_when_emitting, clk_i, rst_ni, rd_valid_q |-> $past(state_q == ST_EMIT))
  `GWWLB_NEVER(a_out_overflow, clk_i, rst_ni, out_cnt_q > OCW'(OUT_DEPTH))

endmodule

// File: src/greedy_word_wrap_line_breaker.sv
// greedy word wrap line breaker: one character in, wrapped lines out as characters
// path: a character that emits a line passes the command queue, the emit state, the registered line store read
//   and the result buffer before its first result shows; the back takes no new character while it emits,
//   and results leave through the single read port of the line store (an empty line still makes one result)
// reset: rst_ni asynchronous active low; clears line state, queues and sets wrap_width to 63
// depends on gwwlb_pkg, gwwlb_front, gwwlb_back
module greedy_word_wrap_line_breaker import gwwlb_pkg::*; #(
  parameter int LineCapacity = LINE_CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // character input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] ch
  // result stream, one transfer per emitted character
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [CHAR_W-1:0]     m_axis_tdata,   // [7:0] out_char
  output logic                  m_axis_tuser,   // [0] empty_line
  output logic                  m_axis_tlast,   // line_end
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int LW = $clog2(LineCapacity + 2);

  logic [WRAP_W-1:0] wrap_width_q, wrap_width_d;
  logic [WRAP_W:0]   width_ext, width_cap;
  logic [LW-1:0]     eff_width;
  logic              reg_sel;
  logic              cfg_write;
  logic              cmd_valid, cmd_pop;
  cmd_t              cmd;

  // config register: written on the access phase
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[APB_ADDR_W-1:2] == REG_WRAP_WIDTH);
  assign cfg_write = psel && penable && pwrite && pready && reg_sel;
  assign prdata    = reg_sel ? APB_DATA_W'(wrap_width_q) : '0;

  always_comb begin
    wrap_width_d = wrap_width_q;
    if (cfg_write) begin
      wrap_width_d = pwdata[WRAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_width_q <= WRAP_WIDTH_RST;
    end else begin
      wrap_width_q <= wrap_width_d;
    end
  end

  // effective width: zero acts as one, capped one below the store capacity
  assign width_ext = {1'b0, wrap_width_q};
  assign width_cap = (WRAP_W+1)'(LineCapacity - 1);
  always_comb begin
    if (wrap_width_q == '0) begin
      eff_width = LW'(1);
    end else if (width_ext > width_cap) begin
      eff_width = LW'(width_cap);
    end else begin
      eff_width = LW'(width_ext);
    end
  end

  // front: accept and classify, short command queue
  gwwlb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // back: line store, word tracking and emission
  gwwlb_back #(
    .LineCapacity (LineCapacity)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .eff_width_i   (eff_width),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: tb/testbench.sv
// self-checking testbench of the greedy word wrap line breaker
// drives characters and wrap_width writes, predicts every emitted character
// depends on gwwlb_pkg and greedy_word_wrap_line_breaker
module testbench;
  import gwwlb_pkg::*;

  localparam int LINE_CAP        = LINE_CAPACITY_DEF;
  localparam int ITEMS_PER_PHASE = 76;
  localparam int NUM_PHASES      = 6;
  localparam int PLAN_ROWS       = 31;
  localparam int SETTLE_CYCLES   = 10;
  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_LIMIT     = 2000;
  localparam int MAX_REPORTS     = 10;
  localparam int SLOW_IDLE_PCT   = 83;
  localparam int LIGHT_IDLE_PCT  = 18;

  // one emitted character as it leaves the result stream
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              empty;
    logic              last;
  } line_res_t;

  typedef enum logic {
    ROW_CHAR,
    ROW_WIDTH
  } row_kind_e;

  // directed stimulus row: a character, or a new wrap width
  typedef struct {
    row_kind_e         kind;
    logic [CHAR_W-1:0] val;
    bit                typed;
    line_res_t         res;
  } plan_row_t;

  localparam line_res_t NO_RES = '0;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [CHAR_W-1:0]     s_axis_tdata;   // [7:0] ch
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [CHAR_W-1:0]     m_axis_tdata;   // [7:0] out_char
  logic                  m_axis_tuser;   // [0] empty_line
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // line model state
  logic [CHAR_W-1:0] line_mem [LINE_CAP];
  int unsigned       line_len;
  int unsigned       word_end;
  int unsigned       word_begin;
  bit                in_word_q;
  logic [WRAP_W-1:0] wrap_cfg;

  line_res_t   step_out [$];   // characters emitted by the latest input
  line_res_t   line_q [$];     // characters still to come from the block
  int unsigned err_cnt;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          rx_hold_req;
  plan_row_t   plan [PLAN_ROWS];

  greedy_word_wrap_line_breaker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_gap(input logic [CHAR_W-1:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VTAB || c == CHAR_FF ||
           c == CHAR_CR;
  endfunction

  function automatic void log_fault(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  function automatic void clear_line();
    line_len   = 0;
    word_end   = 0;
    word_begin = 0;
    in_word_q  = 1'b0;
  endfunction

  // the first n stored characters form one line; no characters gives one empty result
  function automatic void emit_text(input int unsigned n);
    int unsigned cnt;
    cnt = (n > LINE_CAP) ? LINE_CAP : n;
    if (cnt == 0) begin
      step_out.push_back('{ch: '0, empty: 1'b1, last: 1'b1});
    end else begin
      for (int unsigned k = 0; k < cnt; k++) begin
        step_out.push_back('{ch: line_mem[k], empty: 1'b0, last: (k + 1 == cnt)});
      end
    end
  endfunction

  // unfinished word moves to the front and starts the next line
  function automatic void shift_tail(input int unsigned from);
    int unsigned cnt;
    cnt = (from < line_len) ? line_len - from : 0;
    for (int unsigned k = 0; k < cnt; k++) begin
      line_mem[k] = line_mem[from + k];
    end
    line_len   = cnt;
    word_end   = 0;
    word_begin = 0;
    in_word_q  = (cnt > 0);
  endfunction

  // next state of the line for one character, emitted characters land in step_out
  function automatic void predict_wrap(input logic [CHAR_W-1:0] c);
    int unsigned w;
    step_out.delete();
    w = (wrap_cfg == 0) ? 1 : wrap_cfg;
    if (w > LINE_CAP - 1) begin
      w = LINE_CAP - 1;
    end
    if (c == CHAR_NEWLINE) begin
      emit_text(line_len);
      clear_line();
    end else begin
      if (is_gap(c)) begin
        if (in_word_q) begin
          word_end  = line_len;
          in_word_q = 1'b0;
        end
        word_begin = line_len + 1;
      end else begin
        in_word_q = 1'b1;
      end
      if (line_len < LINE_CAP) begin
        line_mem[line_len] = c;
        line_len++;
      end
      if (line_len > w) begin
        if (!in_word_q) begin
          // between words: drop the trailing blanks with the break
          emit_text(word_end);
          clear_line();
        end else if (word_begin == 0) begin
          // no earlier break in this line: hard break at the width
          emit_text(w);
          shift_tail(w);
        end else begin
          emit_text(word_end);
          shift_tail(word_begin);
        end
      end
    end
  endfunction

  // one character transfer; a typed row replaces the predicted line with its own
  task automatic send_char(input logic [CHAR_W-1:0] c, input bit typed, input line_res_t res);
    @(negedge clk_i);
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    predict_wrap(c);
    if (typed) begin
      line_q.push_back(res);
    end else begin
      foreach (step_out[k]) begin
        line_q.push_back(step_out[k]);
      end
    end
  endtask

  // stop sending, let every expected character arrive, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (line_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // wrap_width write; upper data bits carry noise the block must drop
  task automatic set_wrap_width(input logic [WRAP_W-1:0] w);
    logic [APB_DATA_W-1:0] wdata;
    wdata = ($urandom() & ~32'h3f) | APB_DATA_W'(w);
    wait_idle();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WRAP_WIDTH, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    wrap_cfg = wdata[WRAP_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result checker: every accepted transfer against the oldest expectation
  always @(posedge clk_i) begin : check_results
    line_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (line_q.size() == 0) begin
        log_fault($sformatf("unexpected result char=%h empty=%b last=%b",
                            m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = line_q.pop_front();
        // out_char carries no meaning on an empty line
        if (m_axis_tuser !== want.empty || m_axis_tlast !== want.last ||
            (!want.empty && m_axis_tdata !== want.ch)) begin
          log_fault($sformatf("expected char=%h empty=%b last=%b, got char=%h empty=%b last=%b",
                              want.ch, want.empty, want.last,
                              m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end
      end
    end
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin : drive_ready
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        hold_left   = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [WRAP_W-1:0] phase_width [NUM_PHASES];
    logic [CHAR_W-1:0] c;
    int                w_eff;
    int                sent;
    int                pick;
    int                span;
    bit                hold_done;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    err_cnt       = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    rx_hold_req   = 1'b0;
    hold_done     = 1'b0;
    wrap_cfg      = WRAP_WIDTH_RST;
    clear_line();

    // directed rows; the reset width 63 holds until the first width row sets 4, later rows set others
    plan = '{
      '{ROW_CHAR,  CHAR_NEWLINE, 1'b1, '{8'h00, 1'b1, 1'b1}},  // newline on an empty line
      '{ROW_CHAR,  8'h00,        1'b0, NO_RES},
      '{ROW_CHAR,  8'hff,        1'b0, NO_RES},
      '{ROW_CHAR,  CHAR_NEWLINE, 1'b0, NO_RES},
      '{ROW_WIDTH, 8'd4,         1'b0, NO_RES},
      '{ROW_CHAR,  "a",          1'b0, NO_RES},
      '{ROW_CHAR,  "b",          1'b0, NO_RES},
      '{ROW_CHAR,  CHAR_SPACE,   1'b0, NO_RES},
      '{ROW_CHAR,  "c",          1'b0, NO_RES},
      '{ROW_CHAR,  "d",          1'b0, NO_RES},              // wrap inside a word
      '{ROW_CHAR,  CHAR_TAB,     1'b0, NO_RES},
      '{ROW_CHAR,  CHAR_VTAB,    1'b0, NO_RES},
      '{ROW_CHAR,  CHAR_FF,      1'b0, NO_RES},              // wrap between words
      '{ROW_CHAR,  "x",          1'b0, NO_RES},
      '{ROW_CHAR,  "x",          1'b0, NO_RES},
      '{ROW_CHAR,  "x",          1'b0, NO_RES},
      '{ROW_CHAR,  "x",          1'b0, NO_RES},
      '{ROW_CHAR,  "x",          1'b0, NO_RES},              // hard break of a long word
      '{ROW_CHAR,  CHAR_CR,      1'b0, NO_RES},
      '{ROW_CHAR,  CHAR_NEWLINE, 1'b0, NO_RES},
      '{ROW_WIDTH, 8'd0,         1'b0, NO_RES},              // zero acts as one
      '{ROW_CHAR,  "p",          1'b0, NO_RES},
      '{ROW_CHAR,  "q",          1'b1, '{"p", 1'b0, 1'b1}},
      '{ROW_CHAR,  CHAR_NEWLINE, 1'b1, '{"q", 1'b0, 1'b1}},
      '{ROW_WIDTH, 8'd63,        1'b0, NO_RES},
      '{ROW_CHAR,  "m",          1'b0, NO_RES},
      '{ROW_CHAR,  "n",          1'b0, NO_RES},
      '{ROW_CHAR,  "o",          1'b0, NO_RES},
      '{ROW_WIDTH, 8'd1,         1'b0, NO_RES},              // width lowered mid-line
      '{ROW_CHAR,  "r",          1'b1, '{"m", 1'b0, 1'b1}},
      '{ROW_CHAR,  CHAR_NEWLINE, 1'b0, NO_RES}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wrap_width must read back its reset value
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= {REG_WRAP_WIDTH, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    if (prdata[WRAP_W-1:0] !== WRAP_WIDTH_RST) begin
      log_fault($sformatf("expected wrap_width=%0d after reset, got %0d",
                          WRAP_WIDTH_RST, prdata[WRAP_W-1:0]));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WIDTH) begin
        set_wrap_width(plan[r].val[WRAP_W-1:0]);
      end else begin
        send_char(plan[r].val, plan[r].typed, plan[r].res);
      end
    end

    // random text: mostly words and blanks, some newlines and stray bytes
    phase_width = '{6'd1, 6'd63, 6'd0, 6'($urandom_range(2, 62)), 6'd40, 6'd7};
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_wrap_width(phase_width[p]);
      case (p / 2)
        0: begin
          tx_idle_pct = LIGHT_IDLE_PCT;
          rx_idle_pct = SLOW_IDLE_PCT;
        end
        1: begin
          tx_idle_pct = SLOW_IDLE_PCT;
          rx_idle_pct = LIGHT_IDLE_PCT;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      w_eff = (phase_width[p] == 0) ? 1 : phase_width[p];
      sent  = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_char(CHAR_W'($urandom_range(0, 255)), 1'b0, NO_RES);
          sent++;
        end else if (pick < 16) begin
          send_char(CHAR_NEWLINE, 1'b0, NO_RES);
          sent++;
        end else begin
          // a few words run past the width to force hard breaks
          span = (pick < 21) ? $urandom_range(w_eff, w_eff + 3)
                             : $urandom_range(1, (w_eff < 8) ? w_eff + 1 : 8);
          repeat (span) begin
            do begin
              c = CHAR_W'($urandom_range(0, 255));
            end while (c == CHAR_NEWLINE || is_gap(c));
            send_char(c, 1'b0, NO_RES);
            sent++;
          end
          repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 4))
              0:       c = CHAR_TAB;
              1:       c = CHAR_VTAB;
              2:       c = CHAR_FF;
              3:       c = CHAR_CR;
              default: c = CHAR_SPACE;
            endcase
            send_char(c, 1'b0, NO_RES);
            sent++;
          end
        end
        // long receiver hold-off while characters keep coming
        if (p == 4 && sent >= 10 && !hold_done) begin
          rx_hold_req = 1'b1;
          hold_done   = 1'b1;
        end
      end
    end

    wait_idle();
    if (err_cnt == 0 && line_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
